// ===== hw/rtl/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types, character codes and the microprogram of the glob matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

   // Input item kinds carried on req_tuser.
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TEXT   = 2'd2;
   localparam logic [1:0] ACT_END    = 2'd3;

   // Pattern characters with a special meaning.
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QMARK   = 8'h3F;
   localparam logic [7:0] CH_LBR     = 8'h5B;
   localparam logic [7:0] CH_RBR     = 8'h5D;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef logic [4:0] uaddr_type;
   typedef logic [4:0] uop_type;
   typedef logic [3:0] ucond_type;

   // Datapath operations.
   localparam uop_type OP_NOP         = 5'd0;
   localparam uop_type OP_RD_MPOS     = 5'd1;
   localparam uop_type OP_FALLBACK    = 5'd2;
   localparam uop_type OP_STAR_STEP   = 5'd3;
   localparam uop_type OP_SET_WILD    = 5'd4;
   localparam uop_type OP_CLASS_OPEN  = 5'd5;
   localparam uop_type OP_PPOS_STEP   = 5'd6;
   localparam uop_type OP_RANGE       = 5'd7;
   localparam uop_type OP_LIT         = 5'd8;
   localparam uop_type OP_CLASS_CLOSE = 5'd9;
   localparam uop_type OP_GUARD       = 5'd10;
   localparam uop_type OP_HIT         = 5'd11;
   localparam uop_type OP_REJECT      = 5'd12;
   localparam uop_type OP_ACCEPT      = 5'd13;
   localparam uop_type OP_PEEK_NEXT   = 5'd14;
   localparam uop_type OP_EVAL        = 5'd15;
   localparam uop_type OP_EMIT        = 5'd16;

   // Jump conditions.
   localparam ucond_type C_NEVER  = 4'd0;
   localparam ucond_type C_ALWAYS = 4'd1;
   localparam ucond_type C_PNZ    = 4'd2;
   localparam ucond_type C_PZ     = 4'd3;
   localparam ucond_type C_NWILD  = 4'd4;
   localparam ucond_type C_NSTAR  = 4'd5;
   localparam ucond_type C_NLBR   = 4'd6;
   localparam ucond_type C_RBR    = 4'd7;
   localparam ucond_type C_NDASH  = 4'd8;
   localparam ucond_type C_RBZ    = 4'd9;
   localparam ucond_type C_MATCH  = 4'd10;
   localparam ucond_type C_MEQF   = 4'd11;
   localparam ucond_type C_GMORE  = 4'd12;
   localparam ucond_type C_DMADE  = 4'd13;

   // Named program addresses.
   localparam uaddr_type U_LOOP   = 5'd0;
   localparam uaddr_type U_STAR   = 5'd4;
   localparam uaddr_type U_CLASS  = 5'd7;
   localparam uaddr_type U_CLOOP  = 5'd9;
   localparam uaddr_type U_CLIT   = 5'd15;
   localparam uaddr_type U_CCLOSE = 5'd16;
   localparam uaddr_type U_CMP    = 5'd17;
   localparam uaddr_type U_DONE   = 5'd22;
   localparam uaddr_type U_HIT    = 5'd23;
   localparam uaddr_type U_REJECT = 5'd24;
   localparam uaddr_type U_ACCEPT = 5'd25;
   localparam uaddr_type U_EOT    = 5'd26;
   localparam uaddr_type U_EVAL   = 5'd29;
   localparam uaddr_type U_EMIT   = 5'd30;

   typedef struct packed {
      uop_type   op;
      ucond_type cond;
      uaddr_type target;
      logic      fin;
   } ucode_word_type;

   // Status bits that the datapath hands to the sequencer for jumps.
   typedef struct packed {
      logic p_zero;
      logic p_star;
      logic p_lbr;
      logic p_rbr;
      logic p_dash;
      logic wild;
      logic char_hit;
      logic at_fallback;
      logic guard_more;
      logic dmade;
   } cond_flags_type;

   function automatic ucode_word_type uw(input uop_type op, input ucond_type cond,
                                         input uaddr_type target, input logic fin);
      ucode_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.fin    = fin;
      return w;
   endfunction

   // One pass of the text byte loop, then the end of text sequence.
   function automatic ucode_word_type ucode_rom(input uaddr_type addr);
      ucode_word_type w;
      case (addr)
         5'd0:  w = uw(OP_RD_MPOS,     C_NEVER,  U_LOOP,   1'b0);
         5'd1:  w = uw(OP_NOP,         C_PNZ,    U_STAR,   1'b0);
         5'd2:  w = uw(OP_NOP,         C_NWILD,  U_REJECT, 1'b0);
         5'd3:  w = uw(OP_FALLBACK,    C_NEVER,  U_LOOP,   1'b0);
         5'd4:  w = uw(OP_NOP,         C_NSTAR,  U_CLASS,  1'b0);
         5'd5:  w = uw(OP_STAR_STEP,   C_NEVER,  U_LOOP,   1'b0);
         5'd6:  w = uw(OP_SET_WILD,    C_PZ,     U_ACCEPT, 1'b0);
         5'd7:  w = uw(OP_NOP,         C_NLBR,   U_CMP,    1'b0);
         5'd8:  w = uw(OP_CLASS_OPEN,  C_NEVER,  U_LOOP,   1'b0);
         5'd9:  w = uw(OP_NOP,         C_RBR,    U_CCLOSE, 1'b0);
         5'd10: w = uw(OP_NOP,         C_PZ,     U_REJECT, 1'b0);
         5'd11: w = uw(OP_NOP,         C_NDASH,  U_CLIT,   1'b0);
         5'd12: w = uw(OP_PPOS_STEP,   C_NEVER,  U_LOOP,   1'b0);
         5'd13: w = uw(OP_NOP,         C_RBZ,    U_REJECT, 1'b0);
         5'd14: w = uw(OP_RANGE,       C_ALWAYS, U_CLOOP,  1'b0);
         5'd15: w = uw(OP_LIT,         C_ALWAYS, U_CLOOP,  1'b0);
         5'd16: w = uw(OP_CLASS_CLOSE, C_NEVER,  U_LOOP,   1'b0);
         5'd17: w = uw(OP_NOP,         C_MATCH,  U_HIT,    1'b0);
         5'd18: w = uw(OP_NOP,         C_NWILD,  U_REJECT, 1'b0);
         5'd19: w = uw(OP_NOP,         C_MEQF,   U_DONE,   1'b0);
         5'd20: w = uw(OP_FALLBACK,    C_RBR,    U_DONE,   1'b0);
         5'd21: w = uw(OP_GUARD,       C_GMORE,  U_LOOP,   1'b0);
         5'd22: w = uw(OP_NOP,         C_NEVER,  U_LOOP,   1'b1);
         5'd23: w = uw(OP_HIT,         C_NEVER,  U_LOOP,   1'b1);
         5'd24: w = uw(OP_REJECT,      C_NEVER,  U_LOOP,   1'b1);
         5'd25: w = uw(OP_ACCEPT,      C_NEVER,  U_LOOP,   1'b1);
         5'd26: w = uw(OP_RD_MPOS,     C_DMADE,  U_EMIT,   1'b0);
         5'd27: w = uw(OP_NOP,         C_NSTAR,  U_EVAL,   1'b0);
         5'd28: w = uw(OP_PEEK_NEXT,   C_NEVER,  U_LOOP,   1'b0);
         5'd29: w = uw(OP_EVAL,        C_NEVER,  U_LOOP,   1'b0);
         5'd30: w = uw(OP_EMIT,        C_NEVER,  U_LOOP,   1'b1);
         default: w = uw(OP_NOP,       C_NEVER,  U_LOOP,   1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/glob_wildcard_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Streams text bytes against a stored glob pattern with '*', '?' and classes.
// ----------------------------------------------------------------------------
//   Channel   Direction  Beat contents
//   req_*     in         tdata: byte_value[7:0]; tuser: action[1:0]
//   rsp_*     out        tdata: matched[0], zeros above; tuser: pattern_overflow[0]
//
// Clear and append beats do not run the microprogram. A text byte runs it, one
// step per cycle, through at most eight passes of the match loop; a bracket class
// adds steps for each listed byte and each range in it. End of text runs its own
// step sequence. The pattern RAM has a single registered read port. req_tready is
// low while a sequence runs, so the next beat waits for it. Reset is synchronous.
// A waiting result stalls only the emit step of the next end of text.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
   parameter int PATTERN_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // byte_value[7:0]
   input  logic [1:0] req_tuser,   // action[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // matched[0], zero fill [7:1]
   output logic [0:0] rsp_tuser    // pattern_overflow[0]
);

   localparam int PW = $clog2(PATTERN_DEPTH + 1);
   localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   logic [PW-1:0]  plen_ff, plen_in;
   logic           ovf_ff, ovf_in;
   logic [PW-1:0]  mpos_ff, mpos_in;
   logic [PW-1:0]  fpos_ff, fpos_in;
   logic [PW-1:0]  ppos_ff, ppos_in;
   logic           wild_ff, wild_in;
   logic [255:0]   cmap_ff, cmap_in;
   logic [7:0]     lastc_ff, lastc_in;
   logic           dmade_ff, dmade_in;
   logic           dval_ff, dval_in;
   logic [7:0]     tbyte_ff, tbyte_in;
   logic [2:0]     guard_ff, guard_in;
   logic           evalm_ff, evalm_in;
   logic           rdok_ff, rdok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_matched_ff, rsp_matched_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic                    accept;
   logic                    busy;
   logic                    start;
   gwm_pkg::uaddr_type      entry;
   logic                    hold;
   gwm_pkg::ucode_word_type uword;
   gwm_pkg::cond_flags_type flags;
   logic                    emit_fire;

   logic           wr_en;
   logic           rd_en;
   logic [PW-1:0]  rd_pos;
   logic [7:0]     ram_q;
   logic [7:0]     pch;
   logic [PW-1:0]  mpos_inc;
   logic [PW-1:0]  ppos_inc;
   logic [255:0]   range_mask;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy;
   assign hold       = (uword.op == gwm_pkg::OP_EMIT) && rsp_valid_ff && !rsp_tready;
   assign emit_fire  = busy && (uword.op == gwm_pkg::OP_EMIT) && !hold;

   assign mpos_inc = PW'(mpos_ff + 1'b1);
   assign ppos_inc = PW'(ppos_ff + 1'b1);

   // A read at or past the pattern length yields the end marker.
   assign pch = rdok_ff ? ram_q : 8'h00;

   always_comb begin
      for (int i = 0; i < 256; i++) begin
         range_mask[i] = (8'(i) >= lastc_ff) && (8'(i) <= pch);
      end
   end

   assign flags.p_zero      = (pch == 8'h00);
   assign flags.p_star      = (pch == gwm_pkg::CH_STAR);
   assign flags.p_lbr       = (pch == gwm_pkg::CH_LBR);
   assign flags.p_rbr       = (pch == gwm_pkg::CH_RBR);
   assign flags.p_dash      = (pch == gwm_pkg::CH_DASH);
   assign flags.wild        = wild_ff;
   assign flags.char_hit    = (pch == tbyte_ff) || (pch == gwm_pkg::CH_QMARK) ||
                              ((pch == gwm_pkg::CH_RBR) && cmap_ff[tbyte_ff]);
   assign flags.at_fallback = (mpos_ff == fpos_ff);
   assign flags.guard_more  = (guard_ff != 3'd7);
   assign flags.dmade       = dmade_ff;

   // Pattern RAM read address follows the current step.
   always_comb begin
      rd_en  = 1'b0;
      rd_pos = mpos_ff;
      if (busy) begin
         case (uword.op)
            gwm_pkg::OP_RD_MPOS: begin
               rd_en = 1'b1;
            end
            gwm_pkg::OP_FALLBACK: begin
               rd_en  = 1'b1;
               rd_pos = fpos_ff;
            end
            gwm_pkg::OP_STAR_STEP, gwm_pkg::OP_CLASS_OPEN, gwm_pkg::OP_PEEK_NEXT: begin
               rd_en  = 1'b1;
               rd_pos = mpos_inc;
            end
            gwm_pkg::OP_PPOS_STEP, gwm_pkg::OP_RANGE, gwm_pkg::OP_LIT: begin
               rd_en  = 1'b1;
               rd_pos = ppos_inc;
            end
            default: begin
               rd_en = 1'b0;
            end
         endcase
      end
   end

   assign rdok_in = rd_en ? (rd_pos < plen_ff) : rdok_ff;
   assign wr_en   = accept && (req_tuser == gwm_pkg::ACT_APPEND) &&
                    (plen_ff < PW'(PATTERN_DEPTH));

   always_comb begin
      plen_in        = plen_ff;
      ovf_in         = ovf_ff;
      mpos_in        = mpos_ff;
      fpos_in        = fpos_ff;
      ppos_in        = ppos_ff;
      wild_in        = wild_ff;
      cmap_in        = cmap_ff;
      lastc_in       = lastc_ff;
      dmade_in       = dmade_ff;
      dval_in        = dval_ff;
      tbyte_in       = tbyte_ff;
      guard_in       = guard_ff;
      evalm_in       = evalm_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      start          = 1'b0;
      entry          = gwm_pkg::U_LOOP;

      if (accept) begin
         case (req_tuser)
            gwm_pkg::ACT_CLEAR: begin
               plen_in  = '0;
               ovf_in   = 1'b0;
               mpos_in  = '0;
               fpos_in  = '0;
               wild_in  = 1'b0;
               cmap_in  = '0;
               lastc_in = gwm_pkg::CH_LOWER_A;
               dmade_in = 1'b0;
               dval_in  = 1'b0;
            end
            gwm_pkg::ACT_APPEND: begin
               if (wr_en) begin
                  plen_in = PW'(plen_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            gwm_pkg::ACT_TEXT: begin
               // Zero bytes and bytes after a decision leave the state alone.
               if ((req_tdata != 8'h00) && !dmade_ff) begin
                  start    = 1'b1;
                  entry    = gwm_pkg::U_LOOP;
                  tbyte_in = req_tdata;
                  guard_in = 3'd0;
               end
            end
            gwm_pkg::ACT_END: begin
               start = 1'b1;
               entry = gwm_pkg::U_EOT;
            end
            default: begin
               start = 1'b0;
            end
         endcase
      end else if (busy) begin
         case (uword.op)
            gwm_pkg::OP_FALLBACK: begin
               mpos_in = fpos_ff;
            end
            gwm_pkg::OP_STAR_STEP, gwm_pkg::OP_HIT: begin
               mpos_in = mpos_inc;
            end
            gwm_pkg::OP_SET_WILD: begin
               wild_in = 1'b1;
               fpos_in = mpos_ff;
            end
            gwm_pkg::OP_CLASS_OPEN: begin
               cmap_in = '0;
               ppos_in = mpos_inc;
            end
            gwm_pkg::OP_PPOS_STEP: begin
               ppos_in = ppos_inc;
            end
            gwm_pkg::OP_RANGE: begin
               cmap_in = cmap_ff | range_mask;
               ppos_in = ppos_inc;
            end
            gwm_pkg::OP_LIT: begin
               cmap_in  = cmap_ff | (256'd1 << pch);
               lastc_in = pch;
               ppos_in  = ppos_inc;
            end
            gwm_pkg::OP_CLASS_CLOSE: begin
               mpos_in = ppos_ff;
            end
            gwm_pkg::OP_GUARD: begin
               guard_in = guard_ff + 3'd1;
            end
            gwm_pkg::OP_REJECT: begin
               dmade_in = 1'b1;
               dval_in  = 1'b0;
            end
            gwm_pkg::OP_ACCEPT: begin
               dmade_in = 1'b1;
               dval_in  = 1'b1;
            end
            gwm_pkg::OP_EVAL: begin
               evalm_in = (pch == 8'h00);
            end
            gwm_pkg::OP_EMIT: begin
               if (emit_fire) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = (dmade_ff ? dval_ff : evalm_ff) && !ovf_ff;
                  rsp_ovf_in     = ovf_ff;
                  mpos_in        = '0;
                  fpos_in        = '0;
                  wild_in        = 1'b0;
                  cmap_in        = '0;
                  lastc_in       = gwm_pkg::CH_LOWER_A;
                  dmade_in       = 1'b0;
                  dval_in        = 1'b0;
               end
            end
            default: begin
               evalm_in = evalm_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         ovf_ff       <= 1'b0;
         mpos_ff      <= '0;
         fpos_ff      <= '0;
         ppos_ff      <= '0;
         wild_ff      <= 1'b0;
         cmap_ff      <= '0;
         lastc_ff     <= gwm_pkg::CH_LOWER_A;
         dmade_ff     <= 1'b0;
         dval_ff      <= 1'b0;
         rdok_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         ovf_ff       <= ovf_in;
         mpos_ff      <= mpos_in;
         fpos_ff      <= fpos_in;
         ppos_ff      <= ppos_in;
         wild_ff      <= wild_in;
         cmap_ff      <= cmap_in;
         lastc_ff     <= lastc_in;
         dmade_ff     <= dmade_in;
         dval_ff      <= dval_in;
         rdok_ff      <= rdok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tbyte_ff       <= tbyte_in;
      guard_ff       <= guard_in;
      evalm_ff       <= evalm_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   gwm_ram #(
      .WIDTH (8),
      .DEPTH (PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (plen_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_pos[AW-1:0]),
      .rd_data (ram_q)
   );

   gwm_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .entry (entry),
      .hold  (hold),
      .flags (flags),
      .busy  (busy),
      .uword (uword)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_matched_ff};
   assign rsp_tuser  = rsp_ovf_ff;

   // The match and fallback positions never run past the stored pattern.
   a_pos_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (mpos_ff <= plen_ff) && (fpos_ff <= plen_ff))
      else $error("match position beyond pattern length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= PW'(PATTERN_DEPTH))
      else $error("pattern length beyond memory depth");

   // Once latched, a decision holds until end of text or a clear rearms.
   a_decision_latched: assert property (@(posedge clock) disable iff (reset)
      dmade_ff && !emit_fire && !(accept && (req_tuser == gwm_pkg::ACT_CLEAR))
      |=> dmade_ff)
      else $error("early decision lost");

   // A new result beat appears only from the emit step of the sequencer.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(emit_fire))
      else $error("result beat without end of text");

endmodule

// ===== hw/rtl/gwm_ram.sv =====
// ----------------------------------------------------------------------------
// gwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gwm_sequencer.sv =====
// ----------------------------------------------------------------------------
// gwm_sequencer
// Step counter, microprogram table and conditional jump logic.
// ----------------------------------------------------------------------------
module gwm_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  gwm_pkg::uaddr_type      entry,
   input  logic                    hold,
   input  gwm_pkg::cond_flags_type flags,
   output logic                    busy,
   output gwm_pkg::ucode_word_type uword
);

   gwm_pkg::uaddr_type upc_ff, upc_in;
   logic               busy_ff, busy_in;
   logic               take;

   assign uword = gwm_pkg::ucode_rom(upc_ff);
   assign busy  = busy_ff;

   always_comb begin
      case (uword.cond)
         gwm_pkg::C_NEVER:  take = 1'b0;
         gwm_pkg::C_ALWAYS: take = 1'b1;
         gwm_pkg::C_PNZ:    take = !flags.p_zero;
         gwm_pkg::C_PZ:     take = flags.p_zero;
         gwm_pkg::C_NWILD:  take = !flags.wild;
         gwm_pkg::C_NSTAR:  take = !flags.p_star;
         gwm_pkg::C_NLBR:   take = !flags.p_lbr;
         gwm_pkg::C_RBR:    take = flags.p_rbr;
         gwm_pkg::C_NDASH:  take = !flags.p_dash;
         gwm_pkg::C_RBZ:    take = flags.p_rbr || flags.p_zero;
         gwm_pkg::C_MATCH:  take = flags.char_hit;
         gwm_pkg::C_MEQF:   take = flags.at_fallback;
         gwm_pkg::C_GMORE:  take = flags.guard_more;
         gwm_pkg::C_DMADE:  take = flags.dmade;
         default:           take = 1'b0;
      endcase
   end

   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (start) begin
         upc_in  = entry;
         busy_in = 1'b1;
      end else if (busy_ff && !hold) begin
         if (uword.fin) begin
            busy_in = 1'b0;
         end else if (take) begin
            upc_in = uword.target;
         end else begin
            upc_in = upc_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= gwm_pkg::U_LOOP;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
      end
   end

endmodule
